[src/pagd_pkg.sv]
// ----------------------------------------------------------------------------
// pagd_pkg
// Shared widths, Q30 constants, CORDIC angle table and the micro-op table of
// the polarization angle gradient descent unit.
// ----------------------------------------------------------------------------
package pagd_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF   = 18;

	localparam int WF      = 30;
	localparam int ANG_W   = 44;
	localparam int TRIG_W  = 34;
	localparam int ACC_W   = 40;
	localparam int PROD_W  = 64;
	localparam int FIELD_W = 20;
	localparam int UPC_W   = 6;
	localparam int SH_W    = 6;

	localparam logic signed [ANG_W-1:0]  PI_Q      = 44'sd3373259426;
	localparam logic signed [ANG_W-1:0]  TWO_PI_Q  = 44'sd6746518852;
	localparam logic signed [ANG_W-1:0]  HALF_PI_Q = 44'sd1686629713;
	localparam logic signed [ANG_W-1:0]  CLAMP2_Q  = 44'sd2147483648;
	localparam logic signed [TRIG_W-1:0] GAIN_Q    = 34'sd652032874;
	localparam logic signed [TRIG_W-1:0] PI8_Q     = 34'sd421657428;
	localparam logic signed [TRIG_W-1:0] ONE_Q     = 34'sd1073741824;

	localparam logic signed [FIELD_W-1:0] ANG_MAX = 20'sd524287;
	localparam logic signed [FIELD_W-1:0] ANG_MIN = -20'sd524288;

	localparam logic [SH_W-1:0] SH_MAX = 6'd63;

	localparam logic [UPC_W-1:0] F_BASE = 6'd0;
	localparam logic [UPC_W-1:0] G_BASE = 6'd13;

	typedef enum logic [2:0] {
		REG_RETARDER  = 3'd0,
		REG_TARGET_W  = 3'd1,
		REG_TARGET_V  = 3'd2,
		REG_TOLERANCE = 3'd3,
		REG_ITER_LIM  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OPN_CX, OPN_SX, OPN_CY, OPN_SY,
		OPN_TCX, OPN_TSX, OPN_TCY, OPN_TSY,
		OPN_CG, OPN_W, OPN_V, OPN_ONE,
		OPN_P, OPN_ACCQ, OPN_GXQ, OPN_GYQ
	} opnd_t;

	typedef enum logic [2:0] {ACC_NOP, ACC_LD, ACC_LDN, ACC_ADD, ACC_SUB} acc_op_t;
	typedef enum logic [1:0] {F_NOP, F_LD, F_ADD} f_op_t;
	typedef enum logic [2:0] {ST_NONE, ST_GX, ST_GY, ST_XT, ST_YT} st_op_t;

	typedef struct packed {
		opnd_t   a;
		opnd_t   b;
		logic    b_pi8;
		logic    raw;
		acc_op_t acc;
		f_op_t   fop;
		st_op_t  st;
		logic    last;
	} uop_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cx, sx, cy, sy;
		logic signed [TRIG_W-1:0] tcx, tsx, tcy, tsy;
		logic signed [TRIG_W-1:0] cg, w, v, p, accq, gxq, gyq;
	} opnd_bank_t;

	function automatic logic signed [ANG_W-1:0] atan_q(input logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			5'd0: r = 44'sd843314857;
			5'd1: r = 44'sd497837830;
			5'd2: r = 44'sd263043837;
			5'd3: r = 44'sd133525159;
			5'd4: r = 44'sd67021687;
			5'd5: r = 44'sd33543516;
			5'd6: r = 44'sd16775851;
			5'd7: r = 44'sd8388437;
			5'd8: r = 44'sd4194283;
			5'd9: r = 44'sd2097149;
			default: r = $signed(ANG_W'(1) << (5'd30 - i));
		endcase
		return r;
	endfunction

	function automatic logic signed [TRIG_W-1:0] sel_opnd(input opnd_t s, input opnd_bank_t bk);
		logic signed [TRIG_W-1:0] r;
		unique case (s)
			OPN_CX:   r = bk.cx;
			OPN_SX:   r = bk.sx;
			OPN_CY:   r = bk.cy;
			OPN_SY:   r = bk.sy;
			OPN_TCX:  r = bk.tcx;
			OPN_TSX:  r = bk.tsx;
			OPN_TCY:  r = bk.tcy;
			OPN_TSY:  r = bk.tsy;
			OPN_CG:   r = bk.cg;
			OPN_W:    r = bk.w;
			OPN_V:    r = bk.v;
			OPN_ONE:  r = ONE_Q;
			OPN_P:    r = bk.p;
			OPN_ACCQ: r = bk.accq;
			OPN_GXQ:  r = bk.gxq;
			OPN_GYQ:  r = bk.gyq;
		endcase
		return r;
	endfunction

	function automatic uop_t mk(input opnd_t a, input opnd_t b, input logic pi8,
			input logic raw, input acc_op_t ac, input f_op_t fo, input st_op_t st,
			input logic last);
		uop_t u;
		u.a = a; u.b = b; u.b_pi8 = pi8; u.raw = raw;
		u.acc = ac; u.fop = fo; u.st = st; u.last = last;
		return u;
	endfunction

	// F of the trial point at F_BASE, gradients and step at G_BASE
	function automatic uop_t ucode(input logic [UPC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OPN_CG,   OPN_TSX,  1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd1:  u = mk(OPN_P,    OPN_TSY,  1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd2:  u = mk(OPN_TCX,  OPN_TCY,  1'b0, 1'b0, ACC_LDN, F_NOP, ST_NONE, 1'b0);
			6'd3:  u = mk(OPN_W,    OPN_ONE,  1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd4:  u = mk(OPN_ONE,  OPN_ONE,  1'b0, 1'b0, ACC_SUB, F_NOP, ST_NONE, 1'b0);
			6'd5:  u = mk(OPN_ACCQ, OPN_ACCQ, 1'b0, 1'b1, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd6:  u = mk(OPN_CG,   OPN_TCX,  1'b0, 1'b0, ACC_NOP, F_LD,  ST_NONE, 1'b0);
			6'd7:  u = mk(OPN_P,    OPN_TSY,  1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd8:  u = mk(OPN_TSX,  OPN_TCY,  1'b0, 1'b0, ACC_LD,  F_NOP, ST_NONE, 1'b0);
			6'd9:  u = mk(OPN_V,    OPN_ONE,  1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd10: u = mk(OPN_ONE,  OPN_ONE,  1'b0, 1'b0, ACC_SUB, F_NOP, ST_NONE, 1'b0);
			6'd11: u = mk(OPN_ACCQ, OPN_ACCQ, 1'b0, 1'b1, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd12: u = mk(OPN_ONE,  OPN_ONE,  1'b0, 1'b0, ACC_NOP, F_ADD, ST_NONE, 1'b1);
			6'd13: u = mk(OPN_CX,   OPN_CG,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd14: u = mk(OPN_P,    OPN_SY,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd15: u = mk(OPN_P,    OPN_W,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd16: u = mk(OPN_CG,   OPN_SX,   1'b0, 1'b0, ACC_LD,  F_NOP, ST_NONE, 1'b0);
			6'd17: u = mk(OPN_P,    OPN_SY,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd18: u = mk(OPN_P,    OPN_V,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd19: u = mk(OPN_CX,   OPN_CY,   1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd20: u = mk(OPN_P,    OPN_V,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd21: u = mk(OPN_CY,   OPN_SX,   1'b0, 1'b0, ACC_SUB, F_NOP, ST_NONE, 1'b0);
			6'd22: u = mk(OPN_P,    OPN_W,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd23: u = mk(OPN_ONE,  OPN_ONE,  1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd24: u = mk(OPN_CX,   OPN_CY,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_GX,   1'b0);
			6'd25: u = mk(OPN_P,    OPN_CG,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd26: u = mk(OPN_P,    OPN_V,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd27: u = mk(OPN_CY,   OPN_CG,   1'b0, 1'b0, ACC_LDN, F_NOP, ST_NONE, 1'b0);
			6'd28: u = mk(OPN_P,    OPN_CG,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd29: u = mk(OPN_P,    OPN_SY,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd30: u = mk(OPN_CY,   OPN_CG,   1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd31: u = mk(OPN_P,    OPN_SX,   1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd32: u = mk(OPN_P,    OPN_W,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd33: u = mk(OPN_CX,   OPN_SY,   1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd34: u = mk(OPN_P,    OPN_W,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd35: u = mk(OPN_SX,   OPN_SY,   1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd36: u = mk(OPN_P,    OPN_V,    1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b0);
			6'd37: u = mk(OPN_CY,   OPN_SY,   1'b0, 1'b0, ACC_ADD, F_NOP, ST_NONE, 1'b0);
			6'd38: u = mk(OPN_ONE,  OPN_ONE,  1'b0, 1'b0, ACC_SUB, F_NOP, ST_NONE, 1'b0);
			6'd39: u = mk(OPN_GXQ,  OPN_ONE,  1'b1, 1'b1, ACC_NOP, F_NOP, ST_GY,   1'b0);
			6'd40: u = mk(OPN_GYQ,  OPN_ONE,  1'b1, 1'b1, ACC_NOP, F_NOP, ST_XT,   1'b0);
			6'd41: u = mk(OPN_ONE,  OPN_ONE,  1'b0, 1'b0, ACC_NOP, F_NOP, ST_YT,   1'b1);
			default: u = mk(OPN_ONE, OPN_ONE, 1'b0, 1'b0, ACC_NOP, F_NOP, ST_NONE, 1'b1);
		endcase
		return u;
	endfunction

endpackage

[src/polarization_angle_gradient_descent_unit.sv]
// ----------------------------------------------------------------------------
// polarization_angle_gradient_descent_unit
// Sequence: a setup phase (retardance and start point CORDIC runs, start
//   cost), then per descent iteration the gradient and step, two CORDIC
//   runs and the cost, all products on the shared multiplier, for up to
//   iteration_limit + 1 iterations.
// Throughput: one request at a time; busy drops as done is strobed.
// Reset clears the sequencer and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module polarization_angle_gradient_descent_unit #(
	parameter int ANGLE_FRAC_BITS = pagd_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = pagd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pagd_pkg::FIELD_W-1:0]  start_x,
	input  logic signed [pagd_pkg::FIELD_W-1:0]  start_y,
	output logic                                 busy,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_idx,
	input  logic [18:0]                          cfg_wdata,
	output logic                                 done,
	output logic signed [pagd_pkg::FIELD_W-1:0]  result_x,
	output logic signed [pagd_pkg::FIELD_W-1:0]  result_y,
	output logic                                 converged
);
	import pagd_pkg::*;

	localparam int TOQ_SH = WF - ANGLE_FRAC_BITS;
	localparam logic [SH_W-1:0] SH_INIT = SH_W'(50 - ANGLE_FRAC_BITS);

	typedef enum logic [3:0] {
		S_IDLE, S_CG_GO, S_CG_WAIT, S_TX_GO, S_TX_WAIT, S_TY_GO, S_TY_WAIT,
		S_RUN_F, S_CMP, S_ITER, S_RUN_G, S_TOL
	} state_t;

	state_t state_q;
	logic [UPC_W-1:0] upc_q;
	logic [10:0] iter_q;
	logic [SH_W-1:0] sh_q;
	logic init_q, done_q, conv_q;
	logic signed [FIELD_W-1:0] rx_q, ry_q;

	logic [18:0] ret_q;
	logic [17:0] tw_q, tv_q;
	logic [16:0] tol_q;
	logic [9:0] lim_q;

	logic signed [FIELD_W-1:0] x0_q, y0_q, x_q, y_q, xt_q, yt_q;
	logic signed [TRIG_W-1:0] cx_q, sx_q, cy_q, sy_q, tcx_q, tsx_q, tcy_q, tsy_q;
	logic signed [TRIG_W-1:0] cg_q, w_q, v_q;
	logic signed [PROD_W-1:0] p_q, f_q, fp_q;
	logic signed [ACC_W-1:0] acc_q, gx_q, gy_q;

	uop_t uop;
	opnd_bank_t bank;
	logic signed [TRIG_W-1:0] ma, mb;
	logic signed [2*TRIG_W-1:0] prod;
	logic signed [PROD_W-1:0] p_next;
	logic signed [ACC_W-1:0] p_acc;

	logic signed [ANG_W-1:0] w_wide, v_wide, cor_ang;
	logic signed [TRIG_W-1:0] w_clamp, v_clamp;
	logic cor_req, cor_done;
	logic signed [TRIG_W-1:0] cor_cos, cor_sin;

	logic signed [PROD_W-1:0] rnd, step_w;
	logic signed [25:0] step;
	logic signed [26:0] xd, yd;
	logic signed [FIELD_W-1:0] xt_next, yt_next;
	logic signed [FIELD_W:0] ddx, ddy;
	logic [FIELD_W:0] adx, ady;
	logic [FIELD_W+1:0] dsum;
	logic tol_hit, worse, move;

	function automatic logic signed [FIELD_W-1:0] sat_ang(input logic signed [26:0] v);
		logic signed [FIELD_W-1:0] r;
		if (v > 27'(ANG_MAX)) r = ANG_MAX;
		else if (v < 27'(ANG_MIN)) r = ANG_MIN;
		else r = v[FIELD_W-1:0];
		return r;
	endfunction

	assign w_wide = $signed(ANG_W'($signed(tw_q))) <<< TOQ_SH;
	assign v_wide = $signed(ANG_W'($signed(tv_q))) <<< TOQ_SH;
	assign w_clamp = (w_wide > CLAMP2_Q) ? TRIG_W'(CLAMP2_Q) :
		(w_wide < -CLAMP2_Q) ? TRIG_W'(-CLAMP2_Q) : w_wide[TRIG_W-1:0];
	assign v_clamp = (v_wide > CLAMP2_Q) ? TRIG_W'(CLAMP2_Q) :
		(v_wide < -CLAMP2_Q) ? TRIG_W'(-CLAMP2_Q) : v_wide[TRIG_W-1:0];

	always_comb begin
		unique case (state_q)
			S_TX_GO: cor_ang = $signed(ANG_W'(xt_q)) <<< (TOQ_SH + 1);
			S_TY_GO: cor_ang = $signed(ANG_W'(yt_q)) <<< (TOQ_SH + 1);
			default: cor_ang = $signed(ANG_W'(ret_q)) <<< TOQ_SH;
		endcase
	end
	assign cor_req = (state_q == S_CG_GO) || (state_q == S_TX_GO) || (state_q == S_TY_GO);

	pagd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(cor_req), .angle(cor_ang),
		.done(cor_done), .cos_val(cor_cos), .sin_val(cor_sin)
	);

	assign uop = ucode(upc_q);
	assign bank.cx = cx_q;
	assign bank.sx = sx_q;
	assign bank.cy = cy_q;
	assign bank.sy = sy_q;
	assign bank.tcx = tcx_q;
	assign bank.tsx = tsx_q;
	assign bank.tcy = tcy_q;
	assign bank.tsy = tsy_q;
	assign bank.cg = cg_q;
	assign bank.w = w_q;
	assign bank.v = v_q;
	assign bank.p = p_q[TRIG_W-1:0];
	assign bank.accq = TRIG_W'(acc_q >>> 2);
	assign bank.gxq = TRIG_W'(gx_q >>> 8);
	assign bank.gyq = TRIG_W'(gy_q >>> 8);

	assign ma = sel_opnd(uop.a, bank);
	assign mb = uop.b_pi8 ? PI8_Q : sel_opnd(uop.b, bank);
	assign prod = ma * mb;
	assign p_next = uop.raw ? PROD_W'(prod) : PROD_W'(prod >>> WF);
	assign p_acc = p_q[ACC_W-1:0];

	assign rnd = p_q + (PROD_W'(1) <<< (sh_q - 1'b1));
	assign step_w = rnd >>> sh_q;
	assign step = step_w[25:0];
	assign xd = 27'(x_q) - 27'(step);
	assign yd = 27'(y_q) - 27'(step);
	assign xt_next = sat_ang(xd);
	assign yt_next = sat_ang(yd);

	assign ddx = (FIELD_W+1)'(x_q) - (FIELD_W+1)'(xt_q);
	assign ddy = (FIELD_W+1)'(y_q) - (FIELD_W+1)'(yt_q);
	assign adx = ddx[FIELD_W] ? unsigned'(-ddx) : unsigned'(ddx);
	assign ady = ddy[FIELD_W] ? unsigned'(-ddy) : unsigned'(ddy);
	assign dsum = (FIELD_W+2)'(adx) + (FIELD_W+2)'(ady);
	assign tol_hit = dsum < (FIELD_W+2)'(tol_q);

	assign worse = fp_q < f_q;
	assign move = init_q || !worse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upc_q <= F_BASE;
			iter_q <= '0;
			sh_q <= SH_INIT;
			init_q <= 1'b0;
			done_q <= 1'b0;
			conv_q <= 1'b0;
			rx_q <= '0;
			ry_q <= '0;
			ret_q <= '0;
			tw_q <= '0;
			tv_q <= '0;
			tol_q <= 17'd66;
			lim_q <= 10'd1000;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_RETARDER:  ret_q <= cfg_wdata;
					REG_TARGET_W:  tw_q <= cfg_wdata[17:0];
					REG_TARGET_V:  tv_q <= cfg_wdata[17:0];
					REG_TOLERANCE: tol_q <= cfg_wdata[16:0];
					REG_ITER_LIM:  lim_q <= cfg_wdata[9:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CG_GO;
						iter_q <= '0;
						sh_q <= SH_INIT;
						init_q <= 1'b1;
					end
				end
				S_CG_GO: state_q <= S_CG_WAIT;
				S_CG_WAIT: if (cor_done) state_q <= S_TX_GO;
				S_TX_GO: state_q <= S_TX_WAIT;
				S_TX_WAIT: if (cor_done) state_q <= S_TY_GO;
				S_TY_GO: state_q <= S_TY_WAIT;
				S_TY_WAIT: begin
					if (cor_done) begin
						state_q <= S_RUN_F;
						upc_q <= F_BASE;
					end
				end
				S_RUN_F: begin
					if (uop.last) state_q <= S_CMP;
					else upc_q <= upc_q + 1'b1;
				end
				S_CMP: begin
					if (!init_q) begin
						iter_q <= iter_q + 1'b1;
						if (worse && sh_q != SH_MAX) sh_q <= sh_q + 1'b1;
					end
					init_q <= 1'b0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (iter_q > {1'b0, lim_q}) begin
						rx_q <= x0_q;
						ry_q <= y0_q;
						conv_q <= 1'b0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						upc_q <= G_BASE;
						state_q <= S_RUN_G;
					end
				end
				S_RUN_G: begin
					if (uop.last) state_q <= S_TOL;
					else upc_q <= upc_q + 1'b1;
				end
				S_TOL: begin
					if (tol_hit) begin
						rx_q <= xt_q;
						ry_q <= yt_q;
						conv_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TX_GO;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					x0_q <= start_x;
					y0_q <= start_y;
					x_q <= start_x;
					y_q <= start_y;
					xt_q <= start_x;
					yt_q <= start_y;
					w_q <= w_clamp;
					v_q <= v_clamp;
				end
			end
			S_CG_WAIT: if (cor_done) cg_q <= cor_cos;
			S_TX_WAIT: begin
				if (cor_done) begin
					tcx_q <= cor_cos;
					tsx_q <= cor_sin;
				end
			end
			S_TY_WAIT: begin
				if (cor_done) begin
					tcy_q <= cor_cos;
					tsy_q <= cor_sin;
				end
			end
			S_RUN_F, S_RUN_G: begin
				p_q <= p_next;
				unique case (uop.acc)
					ACC_NOP: ;
					ACC_LD:  acc_q <= p_acc;
					ACC_LDN: acc_q <= -p_acc;
					ACC_ADD: acc_q <= acc_q + p_acc;
					ACC_SUB: acc_q <= acc_q - p_acc;
					default: ;
				endcase
				unique case (uop.fop)
					F_NOP: ;
					F_LD:  f_q <= p_q;
					F_ADD: f_q <= f_q + p_q;
					default: ;
				endcase
				unique case (uop.st)
					ST_NONE: ;
					ST_GX: gx_q <= acc_q;
					ST_GY: gy_q <= acc_q;
					ST_XT: xt_q <= xt_next;
					ST_YT: yt_q <= yt_next;
					default: ;
				endcase
			end
			S_CMP: begin
				if (move) begin
					x_q <= xt_q;
					y_q <= yt_q;
					cx_q <= tcx_q;
					sx_q <= tsx_q;
					cy_q <= tcy_q;
					sy_q <= tsy_q;
					fp_q <= f_q;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result_x = rx_q;
	assign result_y = ry_q;
	assign converged = conv_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a running request");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (iter_q <= ({1'b0, lim_q} + 11'd1)))
		else $error("iteration count past the limit");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		sh_q >= SH_INIT)
		else $error("step shift below its start value");
`endif

endmodule

[src/pagd_cordic.sv]
// ----------------------------------------------------------------------------
// pagd_cordic
// Sequential sine/cosine: range reduction by repeated subtraction, fold to
// the right half plane, then one CORDIC rotation stage per cycle.
// ----------------------------------------------------------------------------
module pagd_cordic #(
	parameter int STAGES = pagd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req,
	input  logic signed [pagd_pkg::ANG_W-1:0]    angle,
	output logic                                 done,
	output logic signed [pagd_pkg::TRIG_W-1:0]   cos_val,
	output logic signed [pagd_pkg::TRIG_W-1:0]   sin_val
);
	import pagd_pkg::*;

	localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic [IW-1:0] I_LAST = IW'(STAGES - 1);

	typedef enum logic [2:0] {C_IDLE, C_MOD, C_WRAP, C_FOLD, C_ROT} cst_t;

	cst_t st_q;
	logic [IW-1:0] i_q;
	logic done_q;
	logic signed [ANG_W-1:0] r_q;
	logic signed [TRIG_W-1:0] xv_q, yv_q;
	logic neg_q;
	logic mod_more;
	logic signed [ANG_W-1:0] at;
	logic signed [TRIG_W-1:0] xs, ys;

	assign mod_more = (r_q >= 0) ? (r_q >= TWO_PI_Q) : (r_q <= -TWO_PI_Q);
	assign at = atan_q(5'(i_q));
	assign xs = xv_q >>> i_q;
	assign ys = yv_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			i_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				C_IDLE: if (req) st_q <= C_MOD;
				C_MOD: if (!mod_more) st_q <= C_WRAP;
				C_WRAP: st_q <= C_FOLD;
				C_FOLD: begin
					st_q <= C_ROT;
					i_q <= '0;
				end
				C_ROT: begin
					if (i_q == I_LAST) begin
						st_q <= C_IDLE;
						done_q <= 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			C_IDLE: begin
				if (req) begin
					r_q <= angle;
					xv_q <= GAIN_Q;
					yv_q <= '0;
					neg_q <= 1'b0;
				end
			end
			C_MOD: begin
				if (mod_more) r_q <= (r_q >= 0) ? r_q - TWO_PI_Q : r_q + TWO_PI_Q;
			end
			C_WRAP: begin
				if (r_q > PI_Q) r_q <= r_q - TWO_PI_Q;
				else if (r_q < -PI_Q) r_q <= r_q + TWO_PI_Q;
			end
			C_FOLD: begin
				if (r_q > HALF_PI_Q) begin
					r_q <= r_q - PI_Q;
					neg_q <= 1'b1;
				end else if (r_q < -HALF_PI_Q) begin
					r_q <= r_q + PI_Q;
					neg_q <= 1'b1;
				end
			end
			C_ROT: begin
				if (r_q >= 0) begin
					xv_q <= xv_q - ys;
					yv_q <= yv_q + xs;
					r_q <= r_q - at;
				end else begin
					xv_q <= xv_q + ys;
					yv_q <= yv_q - xs;
					r_q <= r_q + at;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign cos_val = neg_q ? -xv_q : xv_q;
	assign sin_val = neg_q ? -yv_q : yv_q;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polarization angle gradient descent unit. A
// bit-exact descent predictor runs on every accepted request and the result
// strobed on done is compared field by field. Directed phases cover register
// defaults, limit zero, large targets, angle saturation, tiny steps and bad
// register indexes; random phases vary every register and the start angles.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pagd_pkg::*;

	localparam logic [2:0] BAD_IDX = 3'd5;
	localparam longint Q_PI      = 64'sd3373259426;
	localparam longint Q_TWO_PI  = 64'sd6746518852;
	localparam longint Q_HALF_PI = 64'sd1686629713;
	localparam longint Q_PI8     = 64'sd421657428;
	localparam longint Q_GAIN    = 64'sd652032874;
	localparam longint CYCLE_CAP = 64'd4000000;

	typedef struct {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic               conv;
	} angle_pair_t;

	typedef struct {
		longint c, s, cc, ss;
	} trig_set_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic signed [19:0] start_x;
	logic signed [19:0] start_y;
	logic               busy;
	logic               cfg_we;
	logic [2:0]         cfg_idx;
	logic [18:0]        cfg_wdata;
	logic               done;
	logic signed [19:0] result_x;
	logic signed [19:0] result_y;
	logic               converged;

	logic [18:0] m_retarder;
	logic [17:0] m_tw;
	logic [17:0] m_tv;
	logic [16:0] m_tol;
	logic [9:0]  m_lim;
	longint      k_cg, k_w, k_v;

	angle_pair_t solution_q[$];
	int          errors;
	longint      cycles;
	bit          quiet;

	polarization_angle_gradient_descent_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .start_x(start_x),
		.start_y(start_y), .busy(busy), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .done(done), .result_x(result_x),
		.result_y(result_y), .converged(converged)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint to_q(longint v);
		return v * 64'sd16384;
	endfunction

	function automatic void rotate(longint ang, output longint co, output longint si);
		longint r, x, y, at, xs, ys;
		bit neg;
		r = ang % Q_TWO_PI;
		x = Q_GAIN;
		y = 0;
		neg = 1'b0;
		if (r > Q_PI) r -= Q_TWO_PI;
		if (r < -Q_PI) r += Q_TWO_PI;
		if (r > Q_HALF_PI) begin
			r -= Q_PI;
			neg = 1'b1;
		end else if (r < -Q_HALF_PI) begin
			r += Q_PI;
			neg = 1'b1;
		end
		for (int i = 0; i < 18; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			at = i < 10 ? longint'(atan_q(5'(i))) : (64'sd1 <<< (30 - i));
			if (r >= 0) begin
				x -= ys;
				y += xs;
				r -= at;
			end else begin
				x += ys;
				y -= xs;
				r += at;
			end
		end
		co = neg ? -x : x;
		si = neg ? -y : y;
	endfunction

	function automatic trig_set_t angle_trig(longint x, longint y);
		trig_set_t t;
		rotate(2 * to_q(x), t.c, t.s);
		rotate(2 * to_q(y), t.cc, t.ss);
		return t;
	endfunction

	function automatic longint cost(trig_set_t t);
		longint a, b;
		a = qmul(t.c, t.cc) - qmul(qmul(k_cg, t.s), t.ss) - k_w;
		b = qmul(t.s, t.cc) + qmul(qmul(k_cg, t.c), t.ss) - k_v;
		a = a >>> 2;
		b = b >>> 2;
		return a * a + b * b;
	endfunction

	function automatic longint slope_x(trig_set_t t);
		return 4 * qmul(qmul(qmul(t.c, k_cg), t.ss), k_w)
			+ 4 * qmul(qmul(qmul(k_cg, t.s), t.ss), k_v)
			- 4 * qmul(qmul(t.c, t.cc), k_v)
			+ 4 * qmul(qmul(t.cc, t.s), k_w);
	endfunction

	function automatic longint slope_y(trig_set_t t);
		return -4 * qmul(qmul(qmul(t.c, t.cc), k_cg), k_v)
			+ 4 * qmul(qmul(qmul(t.cc, k_cg), k_cg), t.ss)
			+ 4 * qmul(qmul(qmul(t.cc, k_cg), t.s), k_w)
			+ 4 * qmul(qmul(t.c, t.ss), k_w)
			+ 4 * qmul(qmul(t.s, t.ss), k_v)
			- 4 * qmul(t.cc, t.ss);
	endfunction

	function automatic longint step_lsb(longint g, int sh);
		longint p;
		p = (g >>> 10) * Q_PI8;
		return (p + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip_angle(longint v);
		return v > 524287 ? 524287 : (v < -524288 ? -524288 : v);
	endfunction

	function automatic longint clip_two(longint v);
		longint lim;
		lim = 64'sd1 <<< 31;
		return v > lim ? lim : (v < -lim ? -lim : v);
	endfunction

	function automatic angle_pair_t descend(logic signed [19:0] sx, logic signed [19:0] sy);
		angle_pair_t res;
		trig_set_t tp, tt;
		longint x, y, xt, yt, dx, dy, dummy;
		int sh;
		rotate(to_q(longint'(m_retarder)), k_cg, dummy);
		k_w = clip_two(to_q(longint'($signed(m_tw))));
		k_v = clip_two(to_q(longint'($signed(m_tv))));
		x = sx;
		y = sy;
		sh = 34;
		res.x = sx;
		res.y = sy;
		res.conv = 1'b0;
		for (int i = 0; i <= int'(m_lim); i++) begin
			tp = angle_trig(x, y);
			xt = clip_angle(x - step_lsb(slope_x(tp), sh));
			yt = clip_angle(y - step_lsb(slope_y(tp), sh));
			dx = x - xt;
			dy = y - yt;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx + dy < longint'(m_tol)) begin
				res.x = xt[19:0];
				res.y = yt[19:0];
				res.conv = 1'b1;
				break;
			end
			tt = angle_trig(xt, yt);
			if (cost(tp) < cost(tt)) begin
				if (sh < 63) sh++;
			end else begin
				x = xt;
				y = yt;
			end
		end
		return res;
	endfunction

	// check each strobed result against the oldest prediction
	always @(negedge clk) begin
		angle_pair_t e;
		if (arst_n && done) begin
			if (solution_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d conv=%0d", $time,
					result_x, result_y, converged);
				errors++;
			end else begin
				e = solution_q.pop_front();
				if (result_x !== e.x) begin
					$display("%0t: result_x expected %0d actual %0d", $time, e.x, result_x);
					errors++;
				end
				if (result_y !== e.y) begin
					$display("%0t: result_y expected %0d actual %0d", $time, e.y, result_y);
					errors++;
				end
				if (converged !== e.conv) begin
					$display("%0t: converged expected %0d actual %0d", $time, e.conv,
						converged);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send_request(logic signed [19:0] x, logic signed [19:0] y);
		while (!quiet && $urandom_range(99) < 16) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		start_x <= x;
		start_y <= y;
		do @(negedge clk); while (busy);
		@(posedge clk);
		solution_q.push_back(descend(x, y));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (solution_q.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [18:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RETARDER:  m_retarder = val;
			REG_TARGET_W:  m_tw = val[17:0];
			REG_TARGET_V:  m_tv = val[17:0];
			REG_TOLERANCE: m_tol = val[16:0];
			REG_ITER_LIM:  m_lim = val[9:0];
			default: ;
		endcase
	endtask

	task automatic test_defaults();
		send_request(20'sd0, 20'sd0);
		send_request(20'sd51472, -20'sd25736);
	endtask

	task automatic test_limit_zero();
		write_reg(REG_ITER_LIM, 19'd0);
		write_reg(REG_TOLERANCE, 19'd0);
		write_reg(REG_RETARDER, 19'd411775);
		write_reg(REG_TARGET_W, 19'(65536));
		write_reg(REG_TARGET_V, 19'h3_0000);
		send_request(20'sd524287, 20'sd524287);
		send_request(-20'sd524288, -20'sd524288);
		send_request(20'sd524287, -20'sd524288);
	endtask

	task automatic test_large_targets();
		write_reg(REG_ITER_LIM, 19'd12);
		write_reg(REG_TOLERANCE, 19'd66);
		write_reg(REG_TARGET_W, 19'h1_ffff);
		write_reg(REG_TARGET_V, 19'h2_0000);
		send_request(20'sd1000, -20'sd3000);
		write_reg(REG_TARGET_W, 19'h2_0000);
		write_reg(REG_TARGET_V, 19'h1_ffff);
		write_reg(REG_RETARDER, 19'h7_ffff);
		send_request(-20'sd70000, 20'sd9000);
	endtask

	task automatic test_saturation();
		write_reg(REG_RETARDER, 19'd205887);
		write_reg(REG_TARGET_W, 19'h3_0000);
		write_reg(REG_TARGET_V, 19'h1_0000);
		write_reg(REG_ITER_LIM, 19'd20);
		send_request(20'sd524200, 20'sd524100);
		send_request(-20'sd524200, -20'sd524150);
	endtask

	task automatic test_tiny_step();
		write_reg(REG_TOLERANCE, 19'd0);
		write_reg(REG_ITER_LIM, 19'd90);
		write_reg(REG_TARGET_W, 19'd30000);
		write_reg(REG_TARGET_V, 19'h3_8000);
		send_request(20'sd12345, 20'sd54321);
	endtask

	task automatic test_bad_index();
		write_reg(BAD_IDX, 19'h7_ffff);
		write_reg(3'd7, 19'h0_0000);
		send_request(20'sd4000, 20'sd4000);
	endtask

	task automatic test_extreme_limit();
		write_reg(REG_TOLERANCE, 19'h1_ffff);
		write_reg(REG_ITER_LIM, 19'd1023);
		send_request(20'sd77, -20'sd77);
		write_reg(REG_TOLERANCE, 19'h1_0000);
		send_request(-20'sd300000, 20'sd300000);
	endtask

	task automatic test_random();
		for (int p = 0; p < 9; p++) begin
			quiet = (p == 4);
			write_reg(REG_RETARDER, 19'($urandom));
			write_reg(REG_TARGET_W, 19'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072) - 65536));
			write_reg(REG_TARGET_V, 19'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072) - 65536));
			write_reg(REG_TOLERANCE, 19'($urandom_range(1) ? $urandom_range(400) : $urandom));
			write_reg(REG_ITER_LIM, 19'($urandom_range(40)));
			for (int k = 0; k < 11; k++)
				send_request(20'($urandom), 20'($urandom));
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		start_x = '0;
		start_y = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_RETARDER;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		m_retarder = '0;
		m_tw = '0;
		m_tv = '0;
		m_tol = 17'd66;
		m_lim = 10'd1000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_limit_zero();
		test_large_targets();
		test_saturation();
		test_tiny_step();
		test_bad_index();
		test_extreme_limit();
		test_random();
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
